/* hw/rtl/ttmg_pkg.sv */
// ----------------------------------------------------------------------------
// ttmg_pkg
// Shared types and codes of the touch-to-mouse gesture block.
// ----------------------------------------------------------------------------
package ttmg_pkg;

    // Finger event codes on the input channel
    localparam logic [1:0] CMD_DOWN   = 2'd0;
    localparam logic [1:0] CMD_UP     = 2'd1;
    localparam logic [1:0] CMD_MOTION = 2'd2;

    // Mouse event codes on the result channel
    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_UP   = 2'd1;
    localparam logic [1:0] EV_MOVE = 2'd2;
    localparam logic [1:0] EV_MENU = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_WINDOW_WIDTH   = 2'd0;
    localparam logic [1:0] REG_WINDOW_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_MOVE_THRESHOLD = 2'd2;

    localparam logic [13:0] WINDOW_WIDTH_RST   = 14'd1280;
    localparam logic [13:0] WINDOW_HEIGHT_RST  = 14'd720;
    localparam logic [31:0] MOVE_THRESHOLD_RST = 32'd429497;

    localparam logic [12:0] PIX_MAX = 13'h1FFF;

    // Squared distance rescaled to Q0.32 always fits here
    localparam int unsigned DIST_W = 34;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_MULTI  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [13:0] window_width;
        logic [13:0] window_height;
        logic [31:0] move_threshold;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic        button;
        logic [12:0] pixel_x;
        logic [12:0] pixel_y;
        logic        last;
    } result_t;

    // Up to two results produced by one finger event
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

/* hw/rtl/touch_to_mouse_gesture_core.sv */
// ----------------------------------------------------------------------------
// touch_to_mouse_gesture_core
// Turns finger down/up/motion events into mouse clicks, moves and menu events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per finger event, carrying
//   cmd, finger_id and a normalized pos_x/pos_y.
//   Result channel (out_valid/out_ready): zero, one or two beats per event,
//   in order; last marks the final beat caused by an event.
//   Configuration channel (cfg_valid/cfg_ready): cfg_index selects window
//   width, window height or move threshold; write only while idle.
//   Path: an accepted event lands in the input register, is decided there
//   and its results are registered in the result buffer that drives the port.
//   Throughput: one event per cycle while the receiver keeps up; an event
//   that yields two results drains over two result beats, set by the one
//   result beat per cycle that the output port carries.
//   Reset: no finger is tracked, mode is idle, registers take their defaults
//   (1280 x 720, threshold 429497); in_ready is high straight out of reset.
//   Receiver stall: results wait in a two-entry buffer; the held event is
//   decided only once the buffer has room for all of its results, and
//   in_ready drops once the input register is held as well.
// ----------------------------------------------------------------------------
module touch_to_mouse_gesture_core
    import ttmg_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] finger_id,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic        button,
    output logic [12:0] pixel_x,
    output logic [12:0] pixel_y,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t       cfg;
    push_t      push;
    logic [1:0] free;

    // Hold the window size and threshold
    ttmg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Track fingers and decide the mouse results of each event
    ttmg_tracker #(
        .COORD_BITS (COORD_BITS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .finger_id (finger_id),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .cfg       (cfg),
        .free      (free),
        .push      (push)
    );

    // Buffer results and drive the result beats
    ttmg_out_queue u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .free       (free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .button     (button),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last       (last)
    );

endmodule

/* hw/rtl/ttmg_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ttmg_cfg_regs
// Configuration register file: window size and movement threshold.
// ----------------------------------------------------------------------------
module ttmg_cfg_regs
    import ttmg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW_WIDTH:   cfg_next.window_width   = cfg_data[13:0];
                REG_WINDOW_HEIGHT:  cfg_next.window_height  = cfg_data[13:0];
                REG_MOVE_THRESHOLD: cfg_next.move_threshold = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_width   <= WINDOW_WIDTH_RST;
            cfg_reg.window_height  <= WINDOW_HEIGHT_RST;
            cfg_reg.move_threshold <= MOVE_THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/ttmg_tracker.sv */
// ----------------------------------------------------------------------------
// ttmg_tracker
// Input register, two-finger slot table and gesture decision. Produces up
// to two mouse results per finger event, scaled to pixels.
// ----------------------------------------------------------------------------
module ttmg_tracker
    import ttmg_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] finger_id,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  cfg_t        cfg,
    input  logic [1:0]  free,
    output push_t       push
);

    localparam int unsigned POS_W = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int unsigned SQ_W  = 2 * POS_W;
    localparam int unsigned D_W   = SQ_W + 1;
    localparam int unsigned LSH   = (COORD_BITS < 16) ? 2 * (16 - COORD_BITS) : 0;
    localparam int unsigned RSH   = (COORD_BITS > 16) ? 2 * (COORD_BITS - 16) : 0;
    localparam int unsigned PR_W  = POS_W + 14;

    function automatic logic [12:0] to_pixel(input logic [POS_W-1:0] p,
                                             input logic [13:0] s);
        logic [PR_W-1:0] prod;
        logic [PR_W-1:0] sh;
        prod = PR_W'(p) * PR_W'(s);
        sh   = prod >> COORD_BITS;
        return (sh > PR_W'(PIX_MAX)) ? PIX_MAX : sh[12:0];
    endfunction

    // Input register
    logic             inq_valid_reg;
    logic [1:0]       inq_cmd_reg;
    logic [31:0]      inq_id_reg;
    logic [POS_W-1:0] inq_px_reg;
    logic [POS_W-1:0] inq_py_reg;

    // Slot table
    mode_t            mode_reg, mode_next;
    logic             valid_reg [2];
    logic             valid_next [2];
    logic             moved_reg [2];
    logic             moved_next [2];
    logic [31:0]      id_reg [2];
    logic [POS_W-1:0] sx_reg [2];
    logic [POS_W-1:0] sy_reg [2];
    logic [POS_W-1:0] cx_reg [2];
    logic [POS_W-1:0] cy_reg [2];

    // Payload write strobes for the slot table
    logic             start_we;
    logic             cur_we;
    logic             wr_idx;

    logic             hit0, hit1, hit, hs;
    logic [1:0]       count;
    logic [POS_W-1:0] dx, dy;
    logic [SQ_W-1:0]  sqx, sqy;
    logic [D_W-1:0]   dsum;
    logic [DIST_W-1:0] scaled;
    logic             beyond;
    logic [1:0]       n;
    logic             btn;
    logic [POS_W-1:0] ox, oy;
    logic [12:0]      pix_x, pix_y;
    logic             fire;

    assign hit0  = valid_reg[0] && (id_reg[0] == inq_id_reg);
    assign hit1  = valid_reg[1] && (id_reg[1] == inq_id_reg);
    assign hit   = hit0 || hit1;
    assign hs    = !hit0;
    assign count = {1'b0, valid_reg[0]} + {1'b0, valid_reg[1]};

    // Squared distance from the start position, rescaled to Q0.32
    assign dx     = (inq_px_reg > sx_reg[hs]) ? inq_px_reg - sx_reg[hs]
                                               : sx_reg[hs] - inq_px_reg;
    assign dy     = (inq_py_reg > sy_reg[hs]) ? inq_py_reg - sy_reg[hs]
                                               : sy_reg[hs] - inq_py_reg;
    assign sqx    = SQ_W'(dx) * SQ_W'(dx);
    assign sqy    = SQ_W'(dy) * SQ_W'(dy);
    assign dsum   = D_W'(sqx) + D_W'(sqy);
    assign scaled = (DIST_W'(dsum) << LSH) >> RSH;
    assign beyond = scaled > DIST_W'(cfg.move_threshold);

    // An up event reports the finger's last position, others the event's own
    assign ox    = (inq_cmd_reg == CMD_UP) ? cx_reg[hs] : inq_px_reg;
    assign oy    = (inq_cmd_reg == CMD_UP) ? cy_reg[hs] : inq_py_reg;
    assign pix_x = to_pixel(ox, cfg.window_width);
    assign pix_y = to_pixel(oy, cfg.window_height);
    assign btn   = (mode_reg == MODE_MULTI);

    always_comb
    begin
        mode_next     = mode_reg;
        valid_next[0] = valid_reg[0];
        valid_next[1] = valid_reg[1];
        moved_next[0] = moved_reg[0];
        moved_next[1] = moved_reg[1];
        start_we      = 1'b0;
        cur_we        = 1'b0;
        wr_idx        = hs;
        n             = 2'd0;
        push.r0       = '0;
        push.r1       = '0;
        case (inq_cmd_reg)
            CMD_DOWN:
            begin
                if (!hit && count == 2'd2)
                begin
                    // Third finger: open the menu and drop every slot
                    n                = 2'd1;
                    push.r0.event_kind = EV_MENU;
                    valid_next[0]    = 1'b0;
                    valid_next[1]    = 1'b0;
                    moved_next[0]    = 1'b0;
                    moved_next[1]    = 1'b0;
                    mode_next        = MODE_IDLE;
                end
                else
                begin
                    wr_idx             = hit ? hs : valid_reg[0];
                    start_we           = 1'b1;
                    cur_we             = 1'b1;
                    valid_next[wr_idx] = 1'b1;
                    moved_next[wr_idx] = 1'b0;
                    if ((hit ? count : count + 2'd1) == 2'd1)
                        mode_next = MODE_SINGLE;
                    else
                        mode_next = MODE_MULTI;
                end
            end
            CMD_UP:
            begin
                if (hit)
                begin
                    if (count == 2'd1)
                    begin
                        if (mode_reg == MODE_SINGLE || mode_reg == MODE_MULTI)
                        begin
                            if (!moved_reg[hs])
                            begin
                                n                  = 2'd2;
                                push.r0.event_kind = EV_DOWN;
                                push.r0.button     = btn;
                                push.r1.event_kind = EV_UP;
                                push.r1.button     = btn;
                            end
                            else
                            begin
                                n                  = 2'd1;
                                push.r0.event_kind = EV_UP;
                                push.r0.button     = btn;
                            end
                        end
                        mode_next = MODE_IDLE;
                    end
                    valid_next[hs] = 1'b0;
                    moved_next[hs] = 1'b0;
                end
            end
            CMD_MOTION:
            begin
                if (hit && beyond)
                begin
                    moved_next[hs] = 1'b1;
                    cur_we         = 1'b1;
                    if (mode_reg == MODE_SINGLE)
                    begin
                        n                  = 2'd1;
                        push.r0.event_kind = EV_MOVE;
                    end
                end
            end
            default:
            begin
                n = 2'd0;
            end
        endcase
        push.r0.pixel_x = pix_x;
        push.r0.pixel_y = pix_y;
        push.r1.pixel_x = pix_x;
        push.r1.pixel_y = pix_y;
        push.r0.last    = (n == 2'd1);
        push.r1.last    = 1'b1;
        push.n          = (inq_valid_reg && (n <= free)) ? n : 2'd0;
    end

    // Process the held beat once the result buffer has room for all of it
    assign fire     = inq_valid_reg && (n <= free);
    assign in_ready = !inq_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            inq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            inq_cmd_reg <= cmd;
            inq_id_reg  <= finger_id;
            inq_px_reg  <= pos_x[POS_W-1:0];
            inq_py_reg  <= pos_y[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            valid_reg[0] <= 1'b0;
            valid_reg[1] <= 1'b0;
            moved_reg[0] <= 1'b0;
            moved_reg[1] <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            valid_reg[0] <= valid_next[0];
            valid_reg[1] <= valid_next[1];
            moved_reg[0] <= moved_next[0];
            moved_reg[1] <= moved_next[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && start_we)
        begin
            id_reg[wr_idx] <= inq_id_reg;
            sx_reg[wr_idx] <= inq_px_reg;
            sy_reg[wr_idx] <= inq_py_reg;
        end
        if (fire && cur_we)
        begin
            cx_reg[wr_idx] <= inq_px_reg;
            cy_reg[wr_idx] <= inq_py_reg;
        end
    end

endmodule

/* hw/rtl/ttmg_out_queue.sv */
// ----------------------------------------------------------------------------
// ttmg_out_queue
// Two-entry result buffer: takes up to two results at once, drives one beat.
// ----------------------------------------------------------------------------
module ttmg_out_queue
    import ttmg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  push_t       push,
    output logic [1:0]  free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic        button,
    output logic [12:0] pixel_x,
    output logic [12:0] pixel_y,
    output logic        last
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    ent_reg [2];
    result_t    ent_next [2];
    logic       pop;
    logic [1:0] cnt_p;

    assign out_valid  = (cnt_reg != 2'd0);
    assign pop        = out_valid && out_ready;
    assign cnt_p      = cnt_reg - {1'b0, pop};
    assign free       = 2'd2 - cnt_p;
    assign event_kind = ent_reg[0].event_kind;
    assign button     = ent_reg[0].button;
    assign pixel_x    = ent_reg[0].pixel_x;
    assign pixel_y    = ent_reg[0].pixel_y;
    assign last       = ent_reg[0].last;

    always_comb
    begin
        // Advance the head on a pop, then append behind what remains
        ent_next[0] = pop ? ent_reg[1] : ent_reg[0];
        ent_next[1] = ent_reg[1];
        if (push.n != 2'd0)
            ent_next[cnt_p[0]] = push.r0;
        if (push.n == 2'd2)
            ent_next[1] = push.r1;
        cnt_next = cnt_p + push.n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
    end

endmodule

/* tb/tb_touch_to_mouse_gesture_core.sv */
// ----------------------------------------------------------------------------
// tb_touch_to_mouse_gesture_core
// Self-checking bench for the touch-to-mouse gesture block: directed finger
// scenarios, then randomized gesture streams under several window and
// threshold settings, with random idling on both channels and one long
// receiver hold-off. Every result beat is compared with a cycle-free gesture
// tracker that runs alongside the stimulus.
// ----------------------------------------------------------------------------
module tb_touch_to_mouse_gesture_core;
    import ttmg_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int IDLE_PCT      = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 40;
    localparam int HOLD_CYCLES   = 250;

    // Command code that the block must ignore
    localparam logic [1:0] CMD_NONE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [31:0] finger_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  event_kind;
    logic        button;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    touch_to_mouse_gesture_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .finger_id  (finger_id),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .button     (button),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Gesture tracker: the bench's own copy of finger table and settings
    // ------------------------------------------------------------------------
    mode_t       gmode;
    logic        fing_on    [2];
    logic [31:0] fing_id    [2];
    logic [15:0] fing_x0    [2];
    logic [15:0] fing_y0    [2];
    logic [15:0] fing_x     [2];
    logic [15:0] fing_y     [2];
    logic        fing_moved [2];
    logic [13:0] win_w;
    logic [13:0] win_h;
    logic [31:0] move_thr;

    // Mouse events still owed by the block, oldest first
    result_t     mouse_q [$];

    int          error_count;
    int          touches_sent;
    int          cycle_count;
    bit          src_steady;
    bit          sink_steady;
    int          sink_hold;

    // ------------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Stop a hung run; the limit is far beyond the slowest legal run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events owed", cycle_count, mouse_q.size());
            $display("tb_touch_to_mouse_gesture_core: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tracker helpers
    // ------------------------------------------------------------------------
    function automatic logic [12:0] scale_pixel(input logic [15:0] p, input logic [13:0] span);
        logic [29:0] prod;
        prod = p * span;
        // Truncate the fraction, clip to the 13-bit pixel range
        if (prod[29:16] > 14'(PIX_MAX))
            return PIX_MAX;
        return prod[28:16];
    endfunction

    function automatic result_t mouse_event(input logic [1:0] kind, input logic btn,
                                            input logic [15:0] x, input logic [15:0] y);
        result_t r;
        r.event_kind = kind;
        r.button     = btn;
        r.pixel_x    = scale_pixel(x, win_w);
        r.pixel_y    = scale_pixel(y, win_h);
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] sq_dist(input logic [15:0] x, input logic [15:0] y,
                                                  input logic [15:0] x0, input logic [15:0] y0);
        logic [15:0] dx;
        logic [15:0] dy;
        dx = (x > x0) ? x - x0 : x0 - x;
        dy = (y > y0) ? y - y0 : y0 - y;
        return DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
    endfunction

    function automatic void reset_tracker();
        gmode    = MODE_IDLE;
        win_w    = WINDOW_WIDTH_RST;
        win_h    = WINDOW_HEIGHT_RST;
        move_thr = MOVE_THRESHOLD_RST;
        for (int i = 0; i < 2; i++) begin
            fing_on[i]    = 1'b0;
            fing_moved[i] = 1'b0;
        end
    endfunction

    // Advance the finger table by one touch beat and queue what it owes
    function automatic void track_touch(input logic [1:0] c, input logic [31:0] id,
                                        input logic [15:0] x, input logic [15:0] y);
        int      hit;
        int      live;
        int      n;
        logic    btn;
        result_t evs [2];
        hit  = -1;
        n    = 0;
        live = int'(fing_on[0]) + int'(fing_on[1]);
        for (int i = 0; i < 2; i++)
            if (hit < 0 && fing_on[i] && fing_id[i] == id)
                hit = i;
        case (c)
            CMD_DOWN: begin
                if (hit < 0) begin
                    if (live >= 2) begin
                        // Third finger: open the menu and drop every finger
                        evs[n++] = mouse_event(EV_MENU, 1'b0, x, y);
                        for (int i = 0; i < 2; i++) begin
                            fing_on[i]    = 1'b0;
                            fing_moved[i] = 1'b0;
                        end
                        gmode = MODE_IDLE;
                    end else begin
                        hit = fing_on[0] ? 1 : 0;
                        live++;
                    end
                end
                // New or known finger: (re)start it where it touched
                if (hit >= 0) begin
                    fing_on[hit]    = 1'b1;
                    fing_id[hit]    = id;
                    fing_x0[hit]    = x;
                    fing_y0[hit]    = y;
                    fing_x[hit]     = x;
                    fing_y[hit]     = y;
                    fing_moved[hit] = 1'b0;
                    if (live == 1)
                        gmode = MODE_SINGLE;
                    else
                        gmode = MODE_MULTI;
                end
            end
            CMD_UP: begin
                if (hit >= 0) begin
                    // Lifting the last finger clicks; a dragged finger skips the press
                    if (live == 1) begin
                        if (gmode == MODE_SINGLE || gmode == MODE_MULTI) begin
                            btn = (gmode == MODE_MULTI);
                            if (!fing_moved[hit])
                                evs[n++] = mouse_event(EV_DOWN, btn, fing_x[hit], fing_y[hit]);
                            evs[n++] = mouse_event(EV_UP, btn, fing_x[hit], fing_y[hit]);
                        end
                        gmode = MODE_IDLE;
                    end
                    fing_on[hit]    = 1'b0;
                    fing_moved[hit] = 1'b0;
                end
            end
            CMD_MOTION: begin
                if (hit >= 0) begin
                    if (sq_dist(x, y, fing_x0[hit], fing_y0[hit]) > DIST_W'(move_thr)) begin
                        fing_moved[hit] = 1'b1;
                        fing_x[hit]     = x;
                        fing_y[hit]     = y;
                        if (gmode == MODE_SINGLE)
                            evs[n++] = mouse_event(EV_MOVE, 1'b0, x, y);
                    end
                end
            end
            default: ;
        endcase
        if (n > 0)
            evs[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            mouse_q = {mouse_q, evs[i]};
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready with random stalls, plus an on-demand long hold-off
    // ------------------------------------------------------------------------
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (sink_hold > 0) begin
                sink_hold--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= sink_steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS)
            $display("MISMATCH @%0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Compare every accepted result beat with the oldest owed event
    always @(posedge clk) begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (mouse_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0d x %0d y %0d",
                                          event_kind, pixel_x, pixel_y));
            end else begin
                want = mouse_q.pop_front();
                if (event_kind !== want.event_kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d",
                                              event_kind, want.event_kind));
                if (button !== want.button)
                    report_mismatch($sformatf("button %0d, want %0d", button, want.button));
                if (pixel_x !== want.pixel_x)
                    report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, want.pixel_x));
                if (pixel_y !== want.pixel_y)
                    report_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y, want.pixel_y));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d", last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Touch side
    // ------------------------------------------------------------------------
    // Present one touch beat and hold it until taken; valid stays high on
    // return so that a following beat can go out back to back
    task automatic send_touch(input logic [1:0] c, input logic [31:0] id,
                              input logic [15:0] x, input logic [15:0] y);
        while (!src_steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        finger_id <= id;
        pos_x     <= x;
        pos_y     <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_touch(c, id, x, y);
        touches_sent++;
    endtask

    // Drop valid, wait for every owed event, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (mouse_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_WINDOW_WIDTH:   win_w    = data[13:0];
            REG_WINDOW_HEIGHT:  win_h    = data[13:0];
            REG_MOVE_THRESHOLD: move_thr = data;
            default: ;
        endcase
    endtask

    // Write all three registers; only call this once the block is drained.
    // Fill the unused upper bits of the window sizes with junk.
    task automatic write_config(input logic [13:0] w, input logic [13:0] h,
                                input logic [31:0] thr);
        cfg_beat(REG_WINDOW_WIDTH, ($urandom() & 32'hFFFF_C000) | 32'(w));
        cfg_beat(REG_WINDOW_HEIGHT, ($urandom() & 32'hFFFF_C000) | 32'(h));
        cfg_beat(REG_MOVE_THRESHOLD, thr);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random gesture material
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick_id();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_pos();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Small step around a start point, clipped to the coordinate range
    function automatic logic [15:0] nudge_pos(input logic [15:0] p);
        int v;
        v = int'(p) + int'($urandom_range(1200)) - 600;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // Move a finger either a little or anywhere on the surface
    task automatic move_finger(input logic [31:0] id, input logic [15:0] x0,
                               input logic [15:0] y0);
        if ($urandom_range(3) == 0)
            send_touch(CMD_MOTION, id, pick_pos(), pick_pos());
        else
            send_touch(CMD_MOTION, id, nudge_pos(x0), nudge_pos(y0));
    endtask

    // One well-formed gesture with random content, or a short burst of noise
    task automatic play_gesture();
        logic [31:0] ida;
        logic [31:0] idb;
        int          pick;
        int          steps;
        logic [15:0] xa;
        logic [15:0] ya;
        logic [15:0] xb;
        logic [15:0] yb;
        ida  = pick_id();
        idb  = pick_id();
        if (idb == ida)
            idb = ~ida;
        xa    = pick_pos();
        ya    = pick_pos();
        xb    = pick_pos();
        yb    = pick_pos();
        pick  = $urandom_range(99);
        steps = $urandom_range(3);
        if (pick < 45) begin
            // tap or drag with one finger
            send_touch(CMD_DOWN, ida, xa, ya);
            repeat (steps) move_finger(ida, xa, ya);
            send_touch(CMD_UP, ida, pick_pos(), pick_pos());
        end else if (pick < 70) begin
            // two-finger press, lifted in either order
            send_touch(CMD_DOWN, ida, xa, ya);
            send_touch(CMD_DOWN, idb, xb, yb);
            repeat (steps) begin
                if ($urandom_range(1) == 0)
                    move_finger(ida, xa, ya);
                else
                    move_finger(idb, xb, yb);
            end
            if ($urandom_range(1) == 0) begin
                send_touch(CMD_UP, idb, pick_pos(), pick_pos());
                if ($urandom_range(1) == 0)
                    move_finger(ida, xa, ya);
                send_touch(CMD_UP, ida, pick_pos(), pick_pos());
            end else begin
                send_touch(CMD_UP, ida, pick_pos(), pick_pos());
                if ($urandom_range(1) == 0)
                    move_finger(idb, xb, yb);
                send_touch(CMD_UP, idb, pick_pos(), pick_pos());
            end
        end else if (pick < 80) begin
            // third finger opens the menu; the late lift is ignored
            send_touch(CMD_DOWN, ida, xa, ya);
            send_touch(CMD_DOWN, idb, xb, yb);
            send_touch(CMD_DOWN, $urandom(), pick_pos(), pick_pos());
            send_touch(CMD_UP, ida, pick_pos(), pick_pos());
        end else if (pick < 90) begin
            // finger reported down twice restarts at the new spot
            send_touch(CMD_DOWN, ida, xa, ya);
            send_touch(CMD_DOWN, ida, xb, yb);
            if ($urandom_range(1) == 0)
                move_finger(ida, xb, yb);
            send_touch(CMD_UP, ida, pick_pos(), pick_pos());
        end else begin
            // noise: any command, often a stranger's id
            repeat (steps + 1)
                send_touch(2'($urandom_range(3)), ($urandom_range(1) == 0) ? ida : $urandom(),
                           16'($urandom()), 16'($urandom()));
        end
    endtask

    task automatic play_gestures(input int count);
        int goal;
        goal = touches_sent + count;
        while (touches_sent < goal)
            play_gesture();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_single_finger();
        // tap at the far corner with the all-ones id
        send_touch(CMD_DOWN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_touch(CMD_UP, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
        // drag: a jitter below threshold, a real move, then a lift without press
        send_touch(CMD_DOWN, 32'h0000_0000, 16'h0000, 16'h0000);
        send_touch(CMD_MOTION, 32'h0000_0000, 16'h0001, 16'h0001);
        send_touch(CMD_MOTION, 32'h0000_0000, 16'd40000, 16'd30000);
        send_touch(CMD_UP, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_ignored_events();
        send_touch(CMD_NONE, 32'h5A5A_A5A5, 16'hAAAA, 16'h5555);
        send_touch(CMD_UP, 32'h0000_1234, 16'h1234, 16'h4321);
        send_touch(CMD_MOTION, 32'h0000_1234, 16'hFFFF, 16'h0000);
    endtask

    task automatic test_two_fingers();
        // moved second finger in multi mode stays silent; lifts give right click
        send_touch(CMD_DOWN, 32'h0000_00A1, 16'd100, 16'd200);
        send_touch(CMD_DOWN, 32'h0000_00B2, 16'd5000, 16'd6000);
        send_touch(CMD_MOTION, 32'h0000_00B2, 16'd60000, 16'd60000);
        send_touch(CMD_UP, 32'h0000_00B2, 16'd0, 16'd0);
        send_touch(CMD_UP, 32'h0000_00A1, 16'd0, 16'd0);
    endtask

    task automatic test_third_finger();
        send_touch(CMD_DOWN, 32'h1111_1111, 16'd1000, 16'd2000);
        send_touch(CMD_DOWN, 32'h2222_2222, 16'd3000, 16'd4000);
        send_touch(CMD_DOWN, 32'h3333_3333, 16'd50000, 16'd45000);
        send_touch(CMD_UP, 32'h1111_1111, 16'd1000, 16'd2000);
    endtask

    task automatic test_finger_restart();
        send_touch(CMD_DOWN, 32'h8000_0001, 16'd1000, 16'd1000);
        send_touch(CMD_DOWN, 32'h8000_0001, 16'd30000, 16'd20000);
        send_touch(CMD_UP, 32'h8000_0001, 16'd0, 16'd0);
    endtask

    // Stop the receiver for a long stretch while taps keep coming, so the
    // result buffer fills and the input side backs up
    task automatic test_back_pressure();
        src_steady = 1'b1;
        sink_hold  = HOLD_CYCLES;
        repeat (20) begin
            send_touch(CMD_DOWN, 32'h0000_0042, pick_pos(), pick_pos());
            send_touch(CMD_UP, 32'h0000_0042, pick_pos(), pick_pos());
        end
        src_steady = 1'b0;
        drain_results();
    endtask

    // Random streams under extreme and random settings
    task automatic test_config_sweep();
        int span;
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: write_config(14'd16383, 14'd0, 32'd0);
                1: write_config(14'd1, 14'd8192, 32'hFFFF_FFFF);
                2: write_config(14'd8192, 14'd16383, 32'd1);
                default: begin
                    span = $urandom_range(3000);
                    write_config(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                                 32'(span * span));
                end
            endcase
            play_gestures(320);
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        drain_results();
        write_config(WINDOW_WIDTH_RST, WINDOW_HEIGHT_RST, MOVE_THRESHOLD_RST);
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        play_gestures(300);
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        error_count  = 0;
        touches_sent = 0;
        cycle_count  = 0;
        src_steady   = 1'b0;
        sink_steady  = 1'b0;
        sink_hold    = 0;
        in_valid     <= 1'b0;
        cmd          <= CMD_DOWN;
        finger_id    <= '0;
        pos_x        <= '0;
        pos_y        <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_WINDOW_WIDTH;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        reset_tracker();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_single_finger();
        test_ignored_events();
        test_two_fingers();
        test_third_finger();
        test_finger_restart();
        drain_results();
        test_back_pressure();
        test_config_sweep();
        test_steady_stream();
        drain_results();

        if (error_count == 0)
            $display("tb_touch_to_mouse_gesture_core: done, clean");
        else
            $display("tb_touch_to_mouse_gesture_core: done, errors");
        $finish;
    end

endmodule
